// ===== design/assert_macros.svh =====
// Assertion macros used by the checker module of the modular ring ALU.
// Each macro expands to one labeled concurrent assertion clocked on clk.
// The enclosing module must have signals named clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mra_pkg.sv =====
// Package of the modular ring ALU: operation kinds, sequencer states,
// reducer request and response structs and step counts. No dependencies.
`timescale 1ns / 1ps

package mra_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned PROD_W  = 2 * WORD_W;
    localparam int unsigned STEP_W  = 6;

    localparam logic [STEP_W-1:0] STEPS_OPERAND = STEP_W'(WORD_W);
    localparam logic [STEP_W-1:0] STEPS_PRODUCT = STEP_W'(PROD_W);

    localparam logic [WORD_W-1:0] MODULUS_RESET = 16'd7;

    typedef enum logic [3:0] {
        KIND_ADD = 4'd0,
        KIND_SUB = 4'd1,
        KIND_MUL = 4'd2,
        KIND_DIV = 4'd3,
        KIND_EQ  = 4'd4,
        KIND_NE  = 4'd5,
        KIND_LE  = 4'd6,
        KIND_GE  = 4'd7,
        KIND_LT  = 4'd8,
        KIND_GT  = 4'd9
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_OPER,
        ST_SEARCH,
        ST_RED_P,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] value;
        logic [STEP_W-1:0] steps;
    } red_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] rem;
    } red_rsp_t;

endpackage

// ===== design/mra_reduce.sv =====
// Bit-serial modular reducer: shift-and-subtract remainder of a value
// modulo n, one bit per cycle, most significant bit first. Uses mra_pkg.
`timescale 1ns / 1ps

module mra_reduce
    import mra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WORD_W-1:0] n,
    input  red_req_t          req,
    output red_rsp_t          rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [PROD_W-1:0]   shreg_reg, shreg_next;
    logic [WORD_W-1:0]   rem_reg, rem_next;
    logic [WORD_W:0]     trial;

    // The shifted remainder stays below 2n, so one subtract restores it.
    assign trial = {rem_reg, shreg_reg[PROD_W-1]};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shreg_next = shreg_reg;
        rem_next   = rem_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = req.steps;
            shreg_next = req.value;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            shreg_next = {shreg_reg[PROD_W-2:0], 1'b0};
            cnt_next   = cnt_reg - 1'b1;
            if (trial >= {1'b0, n})
            begin
                rem_next = WORD_W'(trial - {1'b0, n});
            end
            else
            begin
                rem_next = trial[WORD_W-1:0];
            end
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shreg_reg <= shreg_next;
        rem_reg   <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== design/modular_ring_alu.sv =====
// Modular ring ALU: add, subtract, multiply, divide and compare modulo n.
// One item at a time: the next is accepted only after the sequencer has
// handed the last result to the output register and returned to idle.
// Reset (rst_n, asynchronous, active low) sets the modulus to 7 and empties
// the block. Depends on mra_pkg and mra_reduce.
`timescale 1ns / 1ps

module modular_ring_alu
    import mra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: the modulus register.
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] left_value, [31:16] right_value
    input  logic [3:0]  s_axis_tuser,  // [3:0] kind
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [15:0] result_value
    output logic [1:0]  m_axis_tuser   // [0] compare_true, [1] no_inverse
);

    // The modulus register. A stored value of zero acts as a modulus of one.
    logic [WORD_W-1:0] mod_reg;
    logic [WORD_W-1:0] n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            mod_reg <= cfg_wdata;
        end
    end

    assign n = (mod_reg == '0) ? WORD_W'(1) : mod_reg;

    // Sequencer and datapath registers.
    state_t            state_reg, state_next;
    kind_t             kind_reg, kind_next;
    logic [WORD_W-1:0] right_reg, right_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] i_reg, i_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic              cmp_reg, cmp_next;
    logic              err_reg, err_next;

    // Output register, which frees the sequencer while a result waits.
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;
    logic              out_cmp_reg, out_cmp_next;
    logic              out_err_reg, out_err_next;

    logic              in_accept;
    logic              out_free;
    red_req_t          red_req;
    red_rsp_t          red_rsp;

    // Shared multiplier: a times b for multiply, a times the inverse for divide.
    logic [WORD_W-1:0] mul_x;
    logic [PROD_W-1:0] product;

    // Shared compare-and-subtract for values known to be below 2n.
    logic [WORD_W:0]   cs_in;
    logic [WORD_W-1:0] cs_out;

    // The block takes a new item only while the sequencer is idle.
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign mul_x   = (state_reg == ST_SEARCH) ? i_reg : b_reg;
    assign product = a_reg * mul_x;

    always_comb
    begin
        if (state_reg == ST_SEARCH)
        begin
            cs_in = {1'b0, acc_reg} + {1'b0, b_reg};
        end
        else if (kind_reg == KIND_SUB)
        begin
            // n + a - b lies in 1 .. 2n-1 because a and b are already reduced.
            cs_in = {1'b0, n} + {1'b0, a_reg} - {1'b0, b_reg};
        end
        else
        begin
            cs_in = {1'b0, a_reg} + {1'b0, b_reg};
        end
    end

    assign cs_out = (cs_in >= {1'b0, n}) ? WORD_W'(cs_in - {1'b0, n}) : cs_in[WORD_W-1:0];

    mra_reduce u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .n     (n),
        .req   (red_req),
        .rsp   (red_rsp)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_RED_A;
                end
            end
            ST_RED_A:
            begin
                if (red_rsp.done)
                begin
                    state_next = ST_RED_B;
                end
            end
            ST_RED_B:
            begin
                if (red_rsp.done)
                begin
                    state_next = ST_OPER;
                end
            end
            ST_OPER:
            begin
                if (kind_reg == KIND_MUL)
                begin
                    state_next = ST_RED_P;
                end
                else if (kind_reg == KIND_DIV && n != WORD_W'(1))
                begin
                    state_next = ST_SEARCH;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SEARCH:
            begin
                if (acc_reg == WORD_W'(1))
                begin
                    state_next = ST_RED_P;
                end
                else if (i_reg == n - 1'b1)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RED_P:
            begin
                if (red_rsp.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and register updates.
    always_comb
    begin
        kind_next      = kind_reg;
        right_next     = right_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        i_next         = i_reg;
        res_next       = res_reg;
        cmp_next       = cmp_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_cmp_next   = out_cmp_reg;
        out_err_next   = out_err_reg;
        red_req.start  = 1'b0;
        red_req.value  = product;
        red_req.steps  = STEPS_PRODUCT;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    kind_next     = kind_t'(s_axis_tuser);
                    right_next    = s_axis_tdata[31:16];
                    res_next      = '0;
                    cmp_next      = 1'b0;
                    err_next      = 1'b0;
                    // A 16-bit operand sits in the top half so 16 steps reduce it.
                    red_req.start = 1'b1;
                    red_req.value = {s_axis_tdata[15:0], WORD_W'(0)};
                    red_req.steps = STEPS_OPERAND;
                end
            end
            ST_RED_A:
            begin
                if (red_rsp.done)
                begin
                    a_next        = red_rsp.rem;
                    red_req.start = 1'b1;
                    red_req.value = {right_reg, WORD_W'(0)};
                    red_req.steps = STEPS_OPERAND;
                end
            end
            ST_RED_B:
            begin
                if (red_rsp.done)
                begin
                    b_next = red_rsp.rem;
                end
            end
            ST_OPER:
            begin
                unique case (kind_reg) inside
                    KIND_ADD, KIND_SUB:
                    begin
                        res_next = cs_out;
                    end
                    KIND_MUL:
                    begin
                        red_req.start = 1'b1;
                    end
                    KIND_DIV:
                    begin
                        // With a modulus of one the search range is empty.
                        if (n == WORD_W'(1))
                        begin
                            err_next = 1'b1;
                        end
                        acc_next = b_reg;
                        i_next   = WORD_W'(1);
                    end
                    KIND_EQ: cmp_next = (a_reg == b_reg);
                    KIND_NE: cmp_next = (a_reg != b_reg);
                    KIND_LE: cmp_next = (a_reg <= b_reg);
                    KIND_GE: cmp_next = (a_reg >= b_reg);
                    KIND_LT: cmp_next = (a_reg < b_reg);
                    KIND_GT: cmp_next = (a_reg > b_reg);
                    default:
                    begin
                        // Unused kinds give all-zero fields.
                        res_next = '0;
                    end
                endcase
            end
            ST_SEARCH:
            begin
                // acc holds b * i mod n for the current candidate i.
                if (acc_reg == WORD_W'(1))
                begin
                    red_req.start = 1'b1;
                end
                else if (i_reg == n - 1'b1)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    i_next   = i_reg + 1'b1;
                    acc_next = cs_out;
                end
            end
            ST_RED_P:
            begin
                if (red_rsp.done)
                begin
                    res_next = red_rsp.rem;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    out_cmp_next   = cmp_reg;
                    out_err_next   = err_reg;
                end
            end
            default:
            begin
                red_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        right_reg    <= right_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        acc_reg      <= acc_next;
        i_reg        <= i_next;
        res_reg      <= res_next;
        cmp_reg      <= cmp_next;
        err_reg      <= err_next;
        out_data_reg <= out_data_next;
        out_cmp_reg  <= out_cmp_next;
        out_err_reg  <= out_err_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = {out_err_reg, out_cmp_reg};

endmodule

// ===== design/mra_checker.sv =====
// Port-level checker for the modular ring ALU and its bind statement.
// Depends on assert_macros.svh and the modular_ring_alu port list.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mra_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result keeps its payload.
    `MRA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // An accepted item keeps the block busy in the following cycle.
    `MRA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after an accepted item")

    // A failed division reports a zero result and no comparison outcome.
    `MRA_ASSERT_IMPL(a_err_clean, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == 16'd0 && !m_axis_tuser[0], "no_inverse with nonzero fields")

    // A true comparison carries a zero result and no error.
    `MRA_ASSERT_IMPL(a_cmp_clean, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 16'd0 && !m_axis_tuser[1], "compare_true with nonzero fields")

endmodule

bind modular_ring_alu mra_checker u_mra_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/tb.sv =====
// Self-checking testbench for modular_ring_alu: directed corner items, then random items
// under a series of moduli. Each result is checked against a built-in ring-arithmetic predictor.
// Depends on mra_pkg (operation kinds) and the modular_ring_alu RTL.
`timescale 1ns / 1ps

module tb;
    import mra_pkg::*;

    // Clock period and run limits, in ns or in cycles as named.
    localparam int unsigned CLK_PERIOD   = 20;
    localparam int unsigned RESET_CYCLES = 8;
    // The block is back at idle by the time its last result leaves, so a short
    // settle before a register write is ample.
    localparam int unsigned SETTLE_CYCLES = 4;
    // The tail outlasts the slowest item besides divide, twice over.
    localparam int unsigned TAIL_CYCLES  = 150;
    // The limit stays well above the slowest correct run, with all divides at
    // their worst.
    localparam longint unsigned RUN_LIMIT_NS = 64'd100_000_000;
    localparam int unsigned KIND_CODES   = 16;
    localparam int unsigned REPORT_MAX   = 10;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS  = 105;
    localparam int unsigned IDLE_PERCENT = 30;
    // Above this modulus a random divide is steered to a divisor of one, since
    // the inverse search runs longer the larger the modulus.
    localparam int unsigned SLOW_DIV_MOD = 4096;

    typedef struct packed {
        logic [15:0] value;
        logic        compare_true;
        logic        no_inverse;
    } ring_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [15:0] left_value, [31:16] right_value
    logic [3:0]  s_axis_tuser;   // [3:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] result_value
    logic [1:0]  m_axis_tuser;   // [0] compare_true, [1] no_inverse

    // Predictor state: the modulus as last written, and the results that are
    // owed by the block in order of acceptance.
    logic [15:0]  ring_modulus;
    ring_result_t pending_results[$];
    int unsigned  err_count;
    // Chance, in percent, that a side idles in a given cycle. Both the sender
    // and the receiver read this, so setting it to zero gives a stretch with
    // full throughput on both sides.
    int unsigned  idle_pct;

    modular_ring_alu u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Computes what the block must return for one item under the current
    // modulus. A modulus of zero acts as one. Divide looks for the smallest
    // inverse of the reduced divisor; finding none gives the error flag.
    function automatic ring_result_t ring_eval(logic [3:0] kind, logic [15:0] left_raw,
                                               logic [15:0] right_raw);
        ring_result_t res;
        logic [31:0]  n;
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  inv;
        res = '0;
        n = (ring_modulus == 16'd0) ? 32'd1 : {16'd0, ring_modulus};
        a = {16'd0, left_raw} % n;
        b = {16'd0, right_raw} % n;
        inv = 32'd0;
        case (kind)
            KIND_ADD: res.value = 16'((a + b) % n);
            KIND_SUB: res.value = 16'((n + a - b) % n);
            KIND_MUL: res.value = 16'((a * b) % n);
            KIND_DIV:
            begin
                for (logic [31:0] i = 32'd1; i < n; i++)
                begin
                    if ((b * i) % n == 32'd1)
                    begin
                        inv = i;
                        break;
                    end
                end
                if (inv == 32'd0)
                    res.no_inverse = 1'b1;
                else
                    res.value = 16'((a * inv) % n);
            end
            KIND_EQ: res.compare_true = (a == b);
            KIND_NE: res.compare_true = (a != b);
            KIND_LE: res.compare_true = (a <= b);
            KIND_GE: res.compare_true = (a >= b);
            KIND_LT: res.compare_true = (a < b);
            KIND_GT: res.compare_true = (a > b);
            default: res = '0;
        endcase
        return res;
    endfunction

    // Sends one item. Random idle cycles come first; valid is not lowered at
    // the end, so back-to-back items keep it high without a glitch. The
    // expectation is queued at the edge where the item is accepted.
    task automatic send_op(logic [3:0] kind, logic [15:0] left_raw, logic [15:0] right_raw);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right_raw, left_raw};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(ring_eval(kind, left_raw, right_raw));
    endtask

    // Drops valid and holds off until every owed result has arrived.
    task automatic await_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes the modulus while the block is idle, and updates the predictor.
    task automatic write_modulus(logic [15:0] modulus);
        await_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= modulus;
        @(negedge clk);
        cfg_we    <= 1'b0;
        ring_modulus = modulus;
    endtask

    // Picks a raw operand: anything in 16 bits, a reduced value, one of 0, n-1,
    // n and all ones, or a multiple of n or one above it, where reduction wraps.
    function automatic logic [15:0] pick_operand(int unsigned n);
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(0, n - 1));
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'd0;
                    1: return 16'(n - 1);
                    2: return 16'(n);
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'(n * $urandom_range(0, 65535 / n) + $urandom_range(0, 1));
        endcase
    endfunction

    // Every kind, including two of the unused codes, at the reset modulus of 7 and
    // with operands at both ends of the 16-bit range.
    task automatic test_reset_modulus();
        send_op(KIND_ADD, 16'hFFFF, 16'hFFFF);
        send_op(KIND_SUB, 16'd0, 16'd6);
        send_op(KIND_MUL, 16'hFFFF, 16'hFFFE);
        send_op(KIND_DIV, 16'd3, 16'd5);
        // A divisor that reduces to zero has no inverse.
        send_op(KIND_DIV, 16'd1, 16'd7);
        send_op(KIND_DIV, 16'hFFFF, 16'd0);
        send_op(KIND_EQ, 16'd7, 16'd14);
        send_op(KIND_NE, 16'd1, 16'd8);
        send_op(KIND_LE, 16'd6, 16'd0);
        send_op(KIND_GE, 16'd0, 16'd6);
        send_op(KIND_LT, 16'd2, 16'd3);
        send_op(KIND_GT, 16'hFFFF, 16'd0);
        send_op(4'(KIND_CODES - 1), 16'hFFFF, 16'hFFFF);
        send_op(4'(int'(KIND_GT) + 1), 16'd5, 16'd3);
    endtask

    // A modulus of zero behaves as one: every value reduces to zero.
    task automatic test_modulus_zero();
        write_modulus(16'd0);
        send_op(KIND_ADD, 16'hFFFF, 16'h1234);
        send_op(KIND_DIV, 16'd9, 16'd1);
        send_op(KIND_GT, 16'hFFFF, 16'd0);
    endtask

    // With modulus one the inverse search is empty, so every divide fails.
    task automatic test_modulus_one();
        write_modulus(16'd1);
        send_op(KIND_DIV, 16'd1, 16'd1);
        send_op(KIND_SUB, 16'd0, 16'hFFFF);
    endtask

    // Largest modulus: wide products, wrap on subtract, and the long searches
    // of a divide by two and a divide by zero.
    task automatic test_largest_modulus();
        write_modulus(16'hFFFF);
        send_op(KIND_ADD, 16'hFFFE, 16'hFFFE);
        send_op(KIND_SUB, 16'd0, 16'd1);
        send_op(KIND_MUL, 16'hFFFE, 16'hFFFE);
        send_op(KIND_DIV, 16'hABCD, 16'd1);
        send_op(KIND_DIV, 16'd1, 16'd2);
        send_op(KIND_DIV, 16'd5, 16'hFFFF);
        send_op(KIND_LT, 16'hFFFF, 16'hFFFE);
    endtask

    // Random items over several moduli, from tiny to near the top of the
    // range. One phase runs with no idling on either side.
    task automatic test_random_moduli();
        int unsigned n;
        logic [15:0] modulus;
        logic [3:0]  kind;
        logic [15:0] right_raw;
        for (int unsigned p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0: modulus = 16'($urandom_range(1, 16));
                1: modulus = 16'($urandom_range(17, 256));
                2: modulus = 16'($urandom_range(257, 2048));
                default: modulus = 16'($urandom_range(SLOW_DIV_MOD, 65535));
            endcase
            write_modulus(modulus);
            idle_pct = (p == 5) ? 0 : IDLE_PERCENT;
            n = int'(modulus);
            for (int unsigned k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    kind = 4'($urandom_range(0, KIND_CODES - 1));
                else
                    kind = 4'($urandom_range(int'(KIND_ADD), int'(KIND_GT)));
                right_raw = pick_operand(n);
                if (kind == KIND_DIV && n > SLOW_DIV_MOD)
                    right_raw = 16'd1;
                send_op(kind, pick_operand(n), right_raw);
            end
        end
        idle_pct = IDLE_PERCENT;
    endtask

    // Receiver: tready idles at random, changing only at the falling edge.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // Result checker: every accepted result is compared with the oldest
    // expectation, field by field.
    ring_result_t want;
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                err_count++;
                if (err_count <= REPORT_MAX)
                    $display("unexpected result: value %0d cmp %0b noinv %0b",
                             m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.value || m_axis_tuser[0] !== want.compare_true
                    || m_axis_tuser[1] !== want.no_inverse)
                begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("result differs: expected value %0d cmp %0b noinv %0b, %s",
                                 want.value, want.compare_true, want.no_inverse,
                                 $sformatf("got value %0d cmp %0b noinv %0b", m_axis_tdata,
                                           m_axis_tuser[0], m_axis_tuser[1]));
                end
            end
        end
    end

    // Main sequence: reset once, run the tests in turn, then drain and report.
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'd0;
        s_axis_tuser  = 4'd0;
        m_axis_tready = 1'b0;
        err_count     = 0;
        idle_pct      = IDLE_PERCENT;
        ring_modulus  = MODULUS_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_modulus();
        test_modulus_zero();
        test_modulus_one();
        test_largest_modulus();
        test_random_moduli();

        await_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("modular_ring_alu: match");
        else
            $display("modular_ring_alu: mismatch");
        $finish;
    end

    // Run limit: a hung handshake ends here.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("modular_ring_alu: mismatch");
        $finish;
    end

endmodule
